>>> src/streaming_find_replace_top_defines.svh
// assertion macros for the streaming find-and-replace block
// no dependencies; taken in by the files that carry assertions
`ifndef STREAMING_FIND_REPLACE_TOP_DEFINES_SVH
`define STREAMING_FIND_REPLACE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define FSR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define FSR_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define FSR_ASSERT(lbl, clk, rst, prop, msg)

`define FSR_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

>>> src/fsr_pkg.sv
// shared constants, types and helpers of the streaming find-and-replace block
// no dependencies; used by the interfaces, controller, datapath and top level
package fsr_pkg;

   // field widths
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 64;
   localparam int LEN_W       = 4;
   localparam int CSR_INDEX_W = 8;

   // default sizes handed to the top level parameters
   localparam int PATTERN_MAX_DEF = 8;
   localparam int REPLACE_MAX_DEF = 8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_BYTES     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH    = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_REPLACEMENT_BYTES = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = CSR_INDEX_W'(3);

   // controller to datapath commands
   typedef struct packed {
      logic load;        // take the accepted byte into the hold buffer
      logic shift_emit;  // send the front held byte and shift the buffer
      logic rep_emit;    // send the next replacement byte
      logic clear_hold;  // empty the hold buffer
   } fsr_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic match;       // the hold buffer equals the whole pattern
      logic prefix_ok;   // the hold buffer is a prefix of the pattern
      logic last;        // the byte being worked on ends the text
      logic cnt_one;     // exactly one byte is held
      logic rep_final;   // the next replacement byte is the final one
      logic out_free;    // the output register can take a byte
   } fsr_status_type;

   // a length of zero acts as one, a length above the maximum acts as the maximum
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw,
                                                   input logic [LEN_W-1:0] max_len);
      logic [LEN_W-1:0] res;
      if (raw == '0) begin
         res = LEN_W'(1);
      end else if (raw > max_len) begin
         res = max_len;
      end else begin
         res = raw;
      end
      return res;
   endfunction

endpackage

>>> src/fsr_if.sv
// channel interfaces of the streaming find-and-replace block
// depends on fsr_pkg for field widths

// source text channel
interface fsr_req_if;
   import fsr_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// substituted text channel
interface fsr_rsp_if;
   import fsr_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_last;
   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// register write channel
interface fsr_csr_if;
   import fsr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [WORD_W-1:0]      wr_data;
   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> src/streaming_find_replace_top.sv
// top level of the streaming find-and-replace block
// depends on fsr_pkg, the channel interfaces, fsr_ctrl and fsr_dp

// Replaces every leftmost, non-overlapping occurrence of a programmed pattern
// (1 to PATTERN_MAX bytes) in a byte stream by a programmed replacement
// (1 to REPLACE_MAX bytes). Bytes that may still start a match are held back;
// in_last flushes the hold and marks the final output byte with out_last.
// A byte is taken in a cycle in which the block is idle and checked in the
// next cycle; a byte that only extends a partial match then lets the block
// go idle again. Each check that finds no prefix sends the front held byte,
// a full match is followed by the replacement bytes, and an end-of-text
// flush without a match sends its held bytes from the check cycle on. All
// output bytes leave through a single output register, one per cycle, and a
// stall on the result channel holds the block. Registers are written through
// the csr channel (always ready) and take effect at once; a write of the
// pattern length drops the held bytes. Writes are meant for idle periods only.
module streaming_find_replace_top #(
   parameter int PATTERN_MAX = fsr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACE_MAX = fsr_pkg::REPLACE_MAX_DEF
) (
   input  logic     clock,
   input  logic     reset,
   fsr_req_if.sink  req_if,
   fsr_rsp_if.source rsp_if,
   fsr_csr_if.sink  csr_if
);
   import fsr_pkg::*;

   fsr_cmd_type    cmd;
   fsr_status_type st;
   logic           req_ready;

   // sequencer
   fsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // registers, hold buffer and output register
   fsr_dp #(
      .PATTERN_MAX (PATTERN_MAX),
      .REPLACE_MAX (REPLACE_MAX)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_byte  (req_if.in_byte),
      .req_last  (req_if.in_last),
      .csr_valid (csr_if.valid),
      .csr_index (csr_if.reg_index),
      .csr_data  (csr_if.wr_data),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_byte  (rsp_if.out_byte),
      .rsp_last  (rsp_if.out_last)
   );

   assign req_if.ready = req_ready;
   assign csr_if.ready = 1'b1;

endmodule

>>> src/fsr_ctrl.sv
// controller of the streaming find-and-replace block: takes a byte, then
// releases, replaces or flushes one output byte per cycle while the output register is free; depends on fsr_pkg
module fsr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fsr_pkg::fsr_status_type st,
   output fsr_pkg::fsr_cmd_type    cmd
);
   import fsr_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_REPL = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (st.match) begin
               state_in = ST_REPL;
            end else if (st.last) begin
               // end of text: everything held goes out
               if (st.out_free) begin
                  cmd.shift_emit = 1'b1;
                  if (st.cnt_one) begin
                     state_in = ST_IDLE;
                  end
               end
            end else if (st.prefix_ok) begin
               state_in = ST_IDLE;
            end else if (st.out_free) begin
               cmd.shift_emit = 1'b1;
            end
         end
         ST_REPL: begin
            if (st.out_free) begin
               cmd.rep_emit = 1'b1;
               if (st.rep_final) begin
                  cmd.clear_hold = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/fsr_dp.sv
// datapath of the streaming find-and-replace block: registers, hold buffer,
// pattern compare, replacement counter and output register; depends on fsr_pkg
`include "streaming_find_replace_top_defines.svh"

module fsr_dp #(
   parameter int PATTERN_MAX = fsr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACE_MAX = fsr_pkg::REPLACE_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fsr_pkg::fsr_cmd_type             cmd,
   output fsr_pkg::fsr_status_type          st,
   input  logic [fsr_pkg::BYTE_W-1:0]      req_byte,
   input  logic                            req_last,
   input  logic                            csr_valid,
   input  logic [fsr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fsr_pkg::WORD_W-1:0]      csr_data,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [fsr_pkg::BYTE_W-1:0]      rsp_byte,
   output logic                            rsp_last
);
   import fsr_pkg::*;

   localparam int CNT_W  = $clog2(PATTERN_MAX + 1);
   localparam int HIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int RCNT_W = $clog2(REPLACE_MAX + 1);
   localparam int RIDX_W = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

   // configuration registers
   logic [WORD_W-1:0] pat_bytes_ff;
   logic [LEN_W-1:0]  pat_len_ff;
   logic [WORD_W-1:0] rep_bytes_ff;
   logic [LEN_W-1:0]  rep_len_ff;

   // hold buffer and working state
   logic [BYTE_W-1:0] hold_ff [PATTERN_MAX];
   logic [BYTE_W-1:0] hold_in [PATTERN_MAX];
   logic [CNT_W-1:0]  hold_cnt_ff;
   logic [CNT_W-1:0]  hold_cnt_in;
   logic              last_ff;
   logic [RIDX_W-1:0] rep_idx_ff;

   // output register
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;

   logic [BYTE_W-1:0] pat_arr [PATTERN_MAX];
   logic [BYTE_W-1:0] rep_arr [REPLACE_MAX];
   logic [LEN_W-1:0]  plen_full;
   logic [LEN_W-1:0]  rlen_full;
   logic [CNT_W-1:0]  plen;
   logic [RCNT_W-1:0] rlen_m1;
   logic              all_eq;
   logic              out_free;
   logic              cnt_one;
   logic              rep_final;

   // byte views of the pattern and replacement words
   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pat
      assign pat_arr[i] = pat_bytes_ff[i*BYTE_W +: BYTE_W];
   end
   for (genvar i = 0; i < REPLACE_MAX; i++) begin : g_rep
      assign rep_arr[i] = rep_bytes_ff[i*BYTE_W +: BYTE_W];
   end

   // effective lengths
   assign plen_full = clamp_len(pat_len_ff, LEN_W'(PATTERN_MAX));
   assign rlen_full = clamp_len(rep_len_ff, LEN_W'(REPLACE_MAX));
   assign plen      = plen_full[CNT_W-1:0];
   assign rlen_m1   = rlen_full[RCNT_W-1:0] - RCNT_W'(1);

   // compare the held bytes against the pattern front
   always_comb begin
      all_eq = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if ((CNT_W'(i) < hold_cnt_ff) && (hold_ff[i] != pat_arr[i])) begin
            all_eq = 1'b0;
         end
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cnt_one   = (hold_cnt_ff == CNT_W'(1));
   assign rep_final = (RCNT_W'(rep_idx_ff) == rlen_m1);

   // status to the controller
   always_comb begin
      st.match     = all_eq && (hold_cnt_ff == plen);
      st.prefix_ok = all_eq && (hold_cnt_ff <= plen);
      st.last      = last_ff;
      st.cnt_one   = cnt_one;
      st.rep_final = rep_final;
      st.out_free  = out_free;
   end

   // next hold buffer contents
   always_comb begin
      hold_in     = hold_ff;
      hold_cnt_in = hold_cnt_ff;
      if (cmd.load) begin
         hold_in[hold_cnt_ff[HIDX_W-1:0]] = req_byte;
         hold_cnt_in = hold_cnt_ff + CNT_W'(1);
      end else if (cmd.shift_emit) begin
         for (int i = 0; i < PATTERN_MAX - 1; i++) begin
            hold_in[i] = hold_ff[i+1];
         end
         hold_cnt_in = hold_cnt_ff - CNT_W'(1);
      end
      if (cmd.clear_hold) begin
         hold_cnt_in = '0;
      end
      // a new pattern length drops whatever is held
      if (csr_valid && (csr_index == REG_PATTERN_LENGTH)) begin
         hold_cnt_in = '0;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_bytes_ff <= '0;
         pat_len_ff   <= LEN_W'(1);
         rep_bytes_ff <= '0;
         rep_len_ff   <= LEN_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            REG_PATTERN_BYTES:      pat_bytes_ff <= csr_data;
            REG_PATTERN_LENGTH:     pat_len_ff   <= csr_data[LEN_W-1:0];
            REG_REPLACEMENT_BYTES:  rep_bytes_ff <= csr_data;
            REG_REPLACEMENT_LENGTH: rep_len_ff   <= csr_data[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // hold buffer bytes and end-of-text flag
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (cmd.load) begin
         last_ff <= req_last;
      end
   end

   // hold count and replacement position
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_cnt_ff <= '0;
         rep_idx_ff  <= '0;
      end else begin
         hold_cnt_ff <= hold_cnt_in;
         if (cmd.load) begin
            rep_idx_ff <= '0;
         end else if (cmd.rep_emit) begin
            rep_idx_ff <= rep_idx_ff + RIDX_W'(1);
         end
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.shift_emit || cmd.rep_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (cmd.shift_emit) begin
         rsp_byte_ff <= hold_ff[0];
         rsp_last_ff <= last_ff && cnt_one;
      end else if (cmd.rep_emit) begin
         rsp_byte_ff <= rep_arr[rep_idx_ff];
         rsp_last_ff <= last_ff && rep_final;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_last  = rsp_last_ff;

   // checks
   `FSR_ASSERT(a_load_below_plen, clock, reset, cmd.load |-> (hold_cnt_ff < plen), "hold buffer not shorter than pattern at load")
   `FSR_ASSERT(a_emit_has_room, clock, reset, (cmd.shift_emit || cmd.rep_emit) |-> out_free, "byte sent while output register full")
   `FSR_ASSERT(a_one_command, clock, reset, $onehot0({cmd.load, cmd.shift_emit, cmd.rep_emit}), "conflicting datapath commands")
   `FSR_ASSERT_NEVER(a_shift_nonempty, clock, reset, cmd.shift_emit && (hold_cnt_ff == '0), "shift of an empty hold buffer")

endmodule

>>> verif/fsr_checker.sv
`timescale 1ns / 1ps
// checker for the streaming find-and-replace block: predicts the substituted text
// from observed register and source transfers, compares every output transfer
// depends on fsr_pkg and the channel interfaces of fsr_if.sv
module fsr_checker
   import fsr_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   parameter int REPLACE_MAX = REPLACE_MAX_DEF
) (
   input  logic clock,
   input  logic reset,
   fsr_req_if   req_if,
   fsr_rsp_if   rsp_if,
   fsr_csr_if   csr_if,
   output int   errors,
   output int   pending
);

   localparam int MAX_OUT = 8;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } text_byte_type;

   // programmed search as seen on the register channel
   logic [WORD_W-1:0] pat_word;
   logic [WORD_W-1:0] rep_word;
   logic [LEN_W-1:0]  pat_len;
   logic [LEN_W-1:0]  rep_len;

   // partial match held back by the block
   logic [BYTE_W-1:0] hold [PATTERN_MAX];
   int                hold_n;
   logic [BYTE_W-1:0] scan [PATTERN_MAX+1];

   text_byte_type due_bytes[$];
   int            err_n = 0;

   assign errors = err_n;

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic int eff_len(input logic [LEN_W-1:0] raw, input int max_len);
      if (raw == '0) return 1;
      if (int'(raw) > max_len) return max_len;
      return int'(raw);
   endfunction

   // scan window slice can still grow into the full pattern
   function automatic bit fits_pattern(input int from, input int len, input int plen);
      if (len > plen) return 1'b0;
      for (int i = 0; i < len; i++) begin
         if (scan[from+i] != pat_word[BYTE_W*i +: BYTE_W]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // work out the output bytes caused by one source byte
   function automatic void substitute(input logic [BYTE_W-1:0] in_b, input logic in_l);
      int            plen;
      int            rlen;
      int            n;
      int            start;
      text_byte_type outs[$];
      plen = eff_len(pat_len, PATTERN_MAX);
      rlen = eff_len(rep_len, REPLACE_MAX);
      n = (hold_n > PATTERN_MAX - 1) ? PATTERN_MAX - 1 : hold_n;
      for (int i = 0; i < n; i++) scan[i] = hold[i];
      scan[n] = in_b;
      n++;
      start = 0;
      // release from the front until the rest is a pattern prefix again
      while (start < n && !fits_pattern(start, n - start, plen)) begin
         outs.push_back(text_byte_type'{scan[start], 1'b0});
         start++;
      end
      if (start < n && n - start == plen) begin
         // full match: the replacement goes out, scanning resumes after it
         for (int i = 0; i < rlen; i++)
            outs.push_back(text_byte_type'{rep_word[BYTE_W*i +: BYTE_W], 1'b0});
         hold_n = 0;
      end else if (in_l) begin
         // end of text flushes the hold
         for (int i = start; i < n; i++) outs.push_back(text_byte_type'{scan[i], 1'b0});
         hold_n = 0;
      end else begin
         hold_n = n - start;
         for (int i = 0; i < hold_n; i++) hold[i] = scan[start+i];
      end
      while (outs.size() > MAX_OUT) void'(outs.pop_back());
      if (in_l && outs.size() > 0) outs[outs.size()-1].last = 1'b1;
      foreach (outs[i]) due_bytes.push_back(outs[i]);
   endfunction

   always @(posedge clock) begin
      text_byte_type want;
      if (reset) begin
         pat_word = '0;
         rep_word = '0;
         pat_len  = LEN_W'(1);
         rep_len  = LEN_W'(1);
         hold_n   = 0;
         foreach (hold[i]) hold[i] = '0;
         due_bytes.delete();
      end else begin
         // register write transfer
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.reg_index)
               REG_PATTERN_BYTES: begin
                  pat_word = csr_if.wr_data;
               end
               REG_PATTERN_LENGTH: begin
                  pat_len = csr_if.wr_data[LEN_W-1:0];
                  hold_n  = 0;
               end
               REG_REPLACEMENT_BYTES: begin
                  rep_word = csr_if.wr_data;
               end
               REG_REPLACEMENT_LENGTH: begin
                  rep_len = csr_if.wr_data[LEN_W-1:0];
               end
               default: begin
               end
            endcase
         end
         // output transfer against the oldest expected byte
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_bytes.size() == 0) begin
               $error("out_byte: expected nothing, got %02h (out_last %0b)",
                      rsp_if.out_byte, rsp_if.out_last);
               err_n++;
            end else begin
               want = due_bytes.pop_front();
               if (rsp_if.out_byte !== want.data) begin
                  $error("out_byte: expected %02h, got %02h", want.data, rsp_if.out_byte);
                  err_n++;
               end
               if (rsp_if.out_last !== want.last) begin
                  $error("out_last: expected %0b, got %0b", want.last, rsp_if.out_last);
                  err_n++;
               end
            end
         end
         // source transfer
         if (req_if.valid && req_if.ready) substitute(req_if.in_byte, req_if.in_last);
      end
      pending <= due_bytes.size();
   end

endmodule

>>> verif/streaming_find_replace_top_tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for the streaming find-and-replace block
// depends on fsr_pkg, fsr_if.sv, streaming_find_replace_top and fsr_checker
module streaming_find_replace_top_tb;
   import fsr_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RAND_PHASES   = 8;
   localparam int PHASE_ITEMS   = 49;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_LOW = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_TOP = '1;

   logic clock;
   logic reset;

   fsr_req_if req_if ();
   fsr_rsp_if rsp_if ();
   fsr_csr_if csr_if ();

   int errors;
   int pending;
   int cycles = 0;
   int sent   = 0;
   bit calm   = 1'b0;   // no idling on either side

   // stimulus-side copy of the programmed search, for building texts
   logic [WORD_W-1:0] pat_word;
   logic [WORD_W-1:0] rep_word;
   int                pat_n;
   int                rep_n;
   logic [BYTE_W-1:0] alphabet [4];

   streaming_find_replace_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   fsr_checker chk (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .csr_if  (csr_if),
      .errors  (errors),
      .pending (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int idle_draw();
      if (calm) return 0;
      return $urandom_range(0, 10);
   endfunction

   function automatic int stim_len(input logic [LEN_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > LEN_W'(PATTERN_MAX_DEF)) return PATTERN_MAX_DEF;
      return int'(raw);
   endfunction

   // mostly legal lengths, sometimes zero or above the maximum
   function automatic logic [LEN_W-1:0] draw_len();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(0, 1) ? LEN_W'(0) : LEN_W'($urandom_range(9, 15));
      return LEN_W'($urandom_range(1, 8));
   endfunction

   // result side: hold ready low for a random stall drawn by idle_draw before each transfer
   initial begin
      int stall;
      forever begin
         stall = idle_draw();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // one source byte transfer; valid stays high when no gap follows
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      req_if.in_last <= l;
      do @(posedge clock); while (!req_if.ready);
      sent++;
   endtask

   // hold off until every expected byte is out and the block is quiet
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wr_data   <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // program all four registers; length words carry random upper bits
   task automatic program_search(input logic [WORD_W-1:0] pw, input logic [LEN_W-1:0] pl,
                                 input logic [WORD_W-1:0] rw, input logic [LEN_W-1:0] rl);
      logic [WORD_W-1:0] upper;
      upper = {$urandom, $urandom};
      write_reg(REG_PATTERN_BYTES, pw);
      write_reg(REG_PATTERN_LENGTH, {upper[WORD_W-1:LEN_W], pl});
      write_reg(REG_REPLACEMENT_BYTES, rw);
      upper = {$urandom, $urandom};
      write_reg(REG_REPLACEMENT_LENGTH, {upper[WORD_W-1:LEN_W], rl});
      pat_word = pw;
      rep_word = rw;
      pat_n    = stim_len(pl);
      rep_n    = stim_len(rl);
   endtask

   // text built from pattern copies, prefixes, replacement copies, near bytes and noise
   task automatic send_text(input int length);
      logic [BYTE_W-1:0] txt[$];
      int                pick;
      int                cut;
      while (txt.size() < length) begin
         pick = $urandom_range(0, 9);
         if (pick <= 3) begin
            for (int i = 0; i < pat_n; i++) txt.push_back(pat_word[BYTE_W*i +: BYTE_W]);
         end else if (pick <= 5) begin
            cut = $urandom_range(1, (pat_n > 1) ? pat_n - 1 : 1);
            for (int i = 0; i < cut; i++) txt.push_back(pat_word[BYTE_W*i +: BYTE_W]);
         end else if (pick <= 7) begin
            txt.push_back(alphabet[$urandom_range(0, 3)]);
         end else if (pick == 8) begin
            txt.push_back(BYTE_W'($urandom));
         end else begin
            for (int i = 0; i < rep_n; i++) txt.push_back(rep_word[BYTE_W*i +: BYTE_W]);
         end
      end
      foreach (txt[i])
         send_byte(txt[i], (i == txt.size() - 1) || ($urandom_range(0, 49) == 0));
   endtask

   initial begin
      logic [WORD_W-1:0] pw;
      int                target;
      bit                first;
      req_if.valid     <= 1'b0;
      req_if.in_byte   <= '0;
      req_if.in_last   <= 1'b0;
      csr_if.valid     <= 1'b0;
      csr_if.reg_index <= REG_PATTERN_BYTES;
      csr_if.wr_data   <= '0;
      reset            <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: a lone zero byte is replaced by a zero byte
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      drain();

      // self-overlapping pattern with fallback, longest replacement
      program_search(64'h0000_0000_4241_4241, LEN_W'(4),
                     64'hFFEE_DDCC_BBAA_9988, LEN_W'(8));
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h55, 1'b1);
      drain();

      // pattern length write drops held bytes; zero length acts as one
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      drain();
      write_reg(REG_PATTERN_LENGTH, {{(WORD_W-LEN_W){1'b1}}, LEN_W'(0)});
      send_byte(8'h42, 1'b1);
      send_byte(8'h41, 1'b1);
      drain();

      // pattern byte write keeps held bytes; oversize length acts as the maximum
      program_search(64'h0807_0605_0403_0201, LEN_W'(15), '0, LEN_W'(0));
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b0);
      drain();
      pat_word = 64'h0807_0605_FF03_0201;
      write_reg(REG_PATTERN_BYTES, pat_word);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(8'h06, 1'b0);
      send_byte(8'h07, 1'b0);
      send_byte(8'h08, 1'b0);
      send_byte(8'h00, 1'b1);
      drain();

      // writes to unused indexes change nothing
      write_reg(REG_UNUSED_LOW, {$urandom, $urandom});
      write_reg(REG_UNUSED_TOP, '1);
      send_byte(8'h01, 1'b1);
      drain();

      // random phases, each with its own search setting
      target = sent;
      for (int p = 0; p < RAND_PHASES; p++) begin
         foreach (alphabet[i]) alphabet[i] = BYTE_W'($urandom);
         if (p == 0) begin
            alphabet = '{8'hFF, 8'h00, 8'hFF, 8'h7F};
            program_search('1, LEN_W'(8), '0, LEN_W'(1));
         end else if (p == 1) begin
            alphabet = '{8'h00, 8'hFF, 8'h00, 8'h80};
            program_search('0, LEN_W'(1), '1, LEN_W'(8));
         end else begin
            for (int i = 0; i < 8; i++) pw[BYTE_W*i +: BYTE_W] = alphabet[$urandom_range(0, 3)];
            program_search(pw, draw_len(), {$urandom, $urandom}, draw_len());
         end
         calm   = (p % 3 == 1);
         target = target + PHASE_ITEMS;
         first  = 1'b1;
         while (sent < target) begin
            send_text($urandom_range(3, 20));
            // after the first text of an even phase, the sender holds off until the block has caught up
            if (first && p % 2 == 0) drain();
            first = 1'b0;
         end
         drain();
      end

      calm = 1'b0;
      drain();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
